FILE: sv/c6502dec_pkg.sv
// Package for the 6502 opcode decoder: mnemonic and addressing-mode codes,
// the opcode lookup tables and the decode functions.
// No dependencies.
`default_nettype none

package c6502dec_pkg;

  typedef enum logic [5:0] {
    MN_ADC = 6'd0,  MN_AND = 6'd1,  MN_ASL = 6'd2,  MN_BCC = 6'd3,
    MN_BCS = 6'd4,  MN_BEQ = 6'd5,  MN_BIT = 6'd6,  MN_BMI = 6'd7,
    MN_BNE = 6'd8,  MN_BPL = 6'd9,  MN_BRK = 6'd10, MN_BVC = 6'd11,
    MN_BVS = 6'd12, MN_CLC = 6'd13, MN_CLD = 6'd14, MN_CLI = 6'd15,
    MN_CLV = 6'd16, MN_CMP = 6'd17, MN_CPX = 6'd18, MN_CPY = 6'd19,
    MN_DEC = 6'd20, MN_DEX = 6'd21, MN_DEY = 6'd22, MN_EOR = 6'd23,
    MN_INC = 6'd24, MN_INX = 6'd25, MN_INY = 6'd26, MN_JMP = 6'd27,
    MN_JSR = 6'd28, MN_LDA = 6'd29, MN_LDX = 6'd30, MN_LDY = 6'd31,
    MN_LSR = 6'd32, MN_NOP = 6'd33, MN_ORA = 6'd34, MN_PHA = 6'd35,
    MN_PHP = 6'd36, MN_PLA = 6'd37, MN_PLP = 6'd38, MN_ROL = 6'd39,
    MN_ROR = 6'd40, MN_RTI = 6'd41, MN_RTS = 6'd42, MN_SBC = 6'd43,
    MN_SEC = 6'd44, MN_SED = 6'd45, MN_SEI = 6'd46, MN_STA = 6'd47,
    MN_STX = 6'd48, MN_STY = 6'd49, MN_TAX = 6'd50, MN_TAY = 6'd51,
    MN_TSX = 6'd52, MN_TXA = 6'd53, MN_TXS = 6'd54, MN_TYA = 6'd55
  } mnemonic_t;

  typedef enum logic [3:0] {
    AM_ABS  = 4'd0,
    AM_IMPL = 4'd1,
    AM_IMM  = 4'd2,
    AM_IND  = 4'd3,
    AM_ZP   = 4'd4,
    AM_ACC  = 4'd5,
    AM_REL  = 4'd6,
    AM_INDY = 4'd7,
    AM_ZPX  = 4'd8,
    AM_ZPY  = 4'd9,
    AM_ABSY = 4'd10,
    AM_ABSX = 4'd11
  } addr_mode_t;

  localparam logic [1:0] GRP_00 = 2'd0;
  localparam logic [1:0] GRP_01 = 2'd1;
  localparam logic [1:0] GRP_10 = 2'd2;
  localparam logic [1:0] GRP_11 = 2'd3;

  localparam logic [2:0] ROW_BIT = 3'd1;
  localparam logic [2:0] ROW_JMP = 3'd3;
  localparam logic [2:0] ROW_ST  = 3'd4;
  localparam logic [2:0] ROW_LD  = 3'd5;
  localparam logic [2:0] COL_IMM = 3'd2;

  // Table entry: bit 6 is the known flag, bits 5-0 the mnemonic.
  typedef logic [6:0] tab_entry_t;

  localparam tab_entry_t EMPTY = 7'd0;

  // Indexed by {row, column}.
  localparam tab_entry_t TAB_G00 [64] = '{
    {1'b1, MN_BRK}, {1'b1, MN_NOP}, {1'b1, MN_PHP}, {1'b1, MN_NOP},
    {1'b1, MN_BPL}, {1'b1, MN_NOP}, {1'b1, MN_CLC}, {1'b1, MN_NOP},
    {1'b1, MN_JSR}, {1'b1, MN_BIT}, {1'b1, MN_PLP}, {1'b1, MN_BIT},
    {1'b1, MN_BMI}, {1'b1, MN_NOP}, {1'b1, MN_SEC}, {1'b1, MN_NOP},
    {1'b1, MN_RTI}, {1'b1, MN_NOP}, {1'b1, MN_PHA}, {1'b1, MN_JMP},
    {1'b1, MN_BVC}, {1'b1, MN_NOP}, {1'b1, MN_CLI}, {1'b1, MN_NOP},
    {1'b1, MN_RTS}, {1'b1, MN_NOP}, {1'b1, MN_PLA}, {1'b1, MN_JMP},
    {1'b1, MN_BVS}, {1'b1, MN_NOP}, {1'b1, MN_SEI}, {1'b1, MN_NOP},
    {1'b1, MN_NOP}, {1'b1, MN_STY}, {1'b1, MN_DEY}, {1'b1, MN_STY},
    {1'b1, MN_BCC}, {1'b1, MN_STY}, {1'b1, MN_TYA}, EMPTY,
    {1'b1, MN_LDY}, {1'b1, MN_LDY}, {1'b1, MN_TAY}, {1'b1, MN_LDY},
    {1'b1, MN_BCS}, {1'b1, MN_LDY}, {1'b1, MN_CLV}, {1'b1, MN_LDY},
    {1'b1, MN_CPY}, {1'b1, MN_CPY}, {1'b1, MN_INY}, {1'b1, MN_CPY},
    {1'b1, MN_BNE}, {1'b1, MN_NOP}, {1'b1, MN_CLD}, {1'b1, MN_NOP},
    {1'b1, MN_CPX}, {1'b1, MN_CPX}, {1'b1, MN_INX}, {1'b1, MN_CPX},
    {1'b1, MN_BEQ}, {1'b1, MN_NOP}, {1'b1, MN_SED}, {1'b1, MN_NOP}
  };

  // Indexed by row.
  localparam tab_entry_t TAB_G01 [8] = '{
    {1'b1, MN_ORA}, {1'b1, MN_AND}, {1'b1, MN_EOR}, {1'b1, MN_ADC},
    {1'b1, MN_STA}, {1'b1, MN_LDA}, {1'b1, MN_CMP}, {1'b1, MN_SBC}
  };

  // Indexed by {row, column}.
  localparam tab_entry_t TAB_G10 [64] = '{
    EMPTY,          {1'b1, MN_ASL}, {1'b1, MN_ASL}, {1'b1, MN_ASL},
    EMPTY,          {1'b1, MN_ASL}, {1'b1, MN_NOP}, {1'b1, MN_ASL},
    EMPTY,          {1'b1, MN_ROL}, {1'b1, MN_ROL}, {1'b1, MN_ROL},
    EMPTY,          {1'b1, MN_ROL}, {1'b1, MN_NOP}, {1'b1, MN_ROL},
    EMPTY,          {1'b1, MN_LSR}, {1'b1, MN_LSR}, {1'b1, MN_LSR},
    EMPTY,          {1'b1, MN_LSR}, {1'b1, MN_NOP}, {1'b1, MN_LSR},
    EMPTY,          {1'b1, MN_ROR}, {1'b1, MN_ROR}, {1'b1, MN_ROR},
    EMPTY,          {1'b1, MN_ROR}, {1'b1, MN_NOP}, {1'b1, MN_ROR},
    {1'b1, MN_NOP}, {1'b1, MN_STX}, {1'b1, MN_TXA}, {1'b1, MN_STX},
    EMPTY,          {1'b1, MN_STX}, {1'b1, MN_TXS}, EMPTY,
    {1'b1, MN_LDX}, {1'b1, MN_LDX}, {1'b1, MN_TAX}, {1'b1, MN_LDX},
    EMPTY,          {1'b1, MN_LDX}, {1'b1, MN_TSX}, {1'b1, MN_LDX},
    {1'b1, MN_NOP}, {1'b1, MN_DEC}, {1'b1, MN_DEX}, {1'b1, MN_DEC},
    EMPTY,          {1'b1, MN_DEC}, {1'b1, MN_NOP}, {1'b1, MN_DEC},
    {1'b1, MN_NOP}, {1'b1, MN_INC}, {1'b1, MN_NOP}, {1'b1, MN_INC},
    EMPTY,          {1'b1, MN_INC}, {1'b1, MN_NOP}, {1'b1, MN_INC}
  };

  function automatic tab_entry_t lookup(input logic [7:0] op);
    logic [2:0] row;
    logic [2:0] col;
    logic [1:0] grp;
    tab_entry_t entry;
    row = op[7:5];
    col = op[4:2];
    grp = op[1:0];
    unique case (grp)
      GRP_00: entry = TAB_G00[{row, col}];
      GRP_01: begin
        if (row == ROW_ST && col == COL_IMM) begin
          entry = {1'b1, MN_NOP};
        end else begin
          entry = TAB_G01[row];
        end
      end
      GRP_10: entry = TAB_G10[{row, col}];
      GRP_11: entry = EMPTY;
      default: entry = EMPTY;
    endcase
    return entry;
  endfunction

  function automatic addr_mode_t mode_of(input logic [7:0] op);
    logic [2:0] row;
    logic [2:0] col;
    logic [1:0] grp;
    logic yidx;
    addr_mode_t mode;
    row = op[7:5];
    col = op[4:2];
    grp = op[1:0];
    yidx = grp[1] && (row == ROW_ST || row == ROW_LD);
    unique case (col)
      3'd0: begin
        if (grp == GRP_00) begin
          if (row == ROW_BIT) begin
            mode = AM_ABS;
          end else if (row <= ROW_JMP) begin
            mode = AM_IMPL;
          end else begin
            mode = AM_IMM;
          end
        end else if (grp == GRP_10) begin
          mode = AM_IMM;
        end else begin
          mode = AM_IND;
        end
      end
      3'd1: mode = AM_ZP;
      3'd2: begin
        if (grp == GRP_00) begin
          mode = AM_IMPL;
        end else if (grp == GRP_10) begin
          mode = (row <= ROW_JMP) ? AM_ACC : AM_IMPL;
        end else begin
          mode = AM_IMM;
        end
      end
      3'd3: mode = (grp == GRP_00 && row == ROW_JMP) ? AM_IND : AM_ABS;
      3'd4: mode = (grp == GRP_00) ? AM_REL : AM_INDY;
      3'd5: mode = yidx ? AM_ZPY : AM_ZPX;
      3'd6: mode = grp[0] ? AM_ABSY : AM_IMPL;
      3'd7: mode = yidx ? AM_ABSY : AM_ABSX;
      default: mode = AM_ABS;
    endcase
    return mode;
  endfunction

endpackage

`default_nettype wire

FILE: sv/cpu6502_opcode_decoder.sv
// Top level of the 6502 opcode decoder: input register, table decode and
// result register. Depends on c6502dec_pkg.
//
//   channel  direction  handshake              payload
//   in       in         in_valid / in_stall    opcode_byte
//   out      out        out_valid / out_stall  known, mnemonic, address_mode
//
// Each request is registered, decoded through the constant tables and
// registered again in the result register.
// One request is taken every cycle while the output is not stalled.
// A stall on the output holds the result register, and the input
// register then holds one more request before in_stall rises.
// Reset clears both valid flags; no request is in flight after reset.
`default_nettype none

module cpu6502_opcode_decoder
  import c6502dec_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] opcode_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            known,
  output logic [5:0]      mnemonic,
  output logic [3:0]      address_mode
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       out_free;
  tab_entry_t entry;
  addr_mode_t mode;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = s1_valid && !out_free;
  assign entry    = lookup(s1_byte);
  assign mode     = mode_of(s1_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
    if (in_valid && !in_stall) begin
      s1_byte <= opcode_byte;
    end
    if (out_free && s1_valid) begin
      known        <= entry[6];
      mnemonic     <= entry[5:0];
      address_mode <= mode;
    end
  end

  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !known |-> mnemonic == MN_ADC)
    else $error("unknown opcode carries a nonzero mnemonic");

  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> address_mode <= AM_ABSX)
    else $error("addressing mode out of range");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled while the pipeline has room");

  a_request_taken: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_valid)
    else $error("accepted request lost in the input register");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Testbench for cpu6502_opcode_decoder: drives opcode bytes through the
// valid/stall input, predicts known, mnemonic and address mode for each
// request and checks every result in order. Depends on c6502dec_pkg.
`timescale 1ns / 1ps

module tb_top;
  import c6502dec_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic       known;
    mnemonic_t  mn;
    addr_mode_t am;
  } decode_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] opcode_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       known;
  logic [5:0] mnemonic;
  logic [3:0] address_mode;

  logic [8:0] pending_ops[$];
  decode_t    expected_decodes[$];
  decode_t    want;
  logic [8:0] next_op;
  int         n_accepted = 0;
  int         n_checked = 0;
  int         errors = 0;
  int         send_gap = 0;
  int         stall_gap = 0;
  int         cycles = 0;
  logic       quiet = 1'b0;

  cpu6502_opcode_decoder dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode_byte(opcode_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .known(known),
    .mnemonic(mnemonic),
    .address_mode(address_mode)
  );

  function automatic mnemonic_t by_row(input logic [2:0] r, input mnemonic_t m0,
                                       input mnemonic_t m1, input mnemonic_t m2,
                                       input mnemonic_t m3, input mnemonic_t m4,
                                       input mnemonic_t m5, input mnemonic_t m6,
                                       input mnemonic_t m7);
    case (r)
      3'd0: return m0;
      3'd1: return m1;
      3'd2: return m2;
      3'd3: return m3;
      3'd4: return m4;
      3'd5: return m5;
      3'd6: return m6;
      default: return m7;
    endcase
  endfunction

  function automatic decode_t decode_opcode(input logic [7:0] op);
    logic [2:0] row;
    logic [2:0] col;
    logic [1:0] grp;
    logic       yidx;
    decode_t    d;
    row = op[7:5];
    col = op[4:2];
    grp = op[1:0];
    d.known = 1'b1;
    d.mn = MN_NOP;
    d.am = AM_ABS;
    case (grp)
      GRP_00: begin
        case (col)
          3'd0: d.mn = by_row(row, MN_BRK, MN_JSR, MN_RTI, MN_RTS,
                              MN_NOP, MN_LDY, MN_CPY, MN_CPX);
          3'd2: d.mn = by_row(row, MN_PHP, MN_PLP, MN_PHA, MN_PLA,
                              MN_DEY, MN_TAY, MN_INY, MN_INX);
          3'd4: d.mn = by_row(row, MN_BPL, MN_BMI, MN_BVC, MN_BVS,
                              MN_BCC, MN_BCS, MN_BNE, MN_BEQ);
          3'd6: d.mn = by_row(row, MN_CLC, MN_SEC, MN_CLI, MN_SEI,
                              MN_TYA, MN_CLV, MN_CLD, MN_SED);
          default: begin
            case (row)
              3'd1: d.mn = (col == 3'd1 || col == 3'd3) ? MN_BIT : MN_NOP;
              3'd2, 3'd3: d.mn = (col == 3'd3) ? MN_JMP : MN_NOP;
              3'd4: begin
                if (col == 3'd7) begin
                  d.known = 1'b0;
                end else begin
                  d.mn = MN_STY;
                end
              end
              3'd5: d.mn = MN_LDY;
              3'd6: d.mn = (col <= 3'd3) ? MN_CPY : MN_NOP;
              3'd7: d.mn = (col <= 3'd3) ? MN_CPX : MN_NOP;
              default: d.mn = MN_NOP;
            endcase
          end
        endcase
      end
      GRP_01: begin
        if (row == 3'd4 && col == 3'd2) begin
          d.mn = MN_NOP;
        end else begin
          d.mn = by_row(row, MN_ORA, MN_AND, MN_EOR, MN_ADC,
                        MN_STA, MN_LDA, MN_CMP, MN_SBC);
        end
      end
      GRP_10: begin
        case (col)
          3'd0: begin
            if (row <= 3'd3) begin
              d.known = 1'b0;
            end else begin
              d.mn = (row == 3'd5) ? MN_LDX : MN_NOP;
            end
          end
          3'd2: d.mn = by_row(row, MN_ASL, MN_ROL, MN_LSR, MN_ROR,
                              MN_TXA, MN_TAX, MN_DEX, MN_NOP);
          3'd4: d.known = 1'b0;
          3'd6: d.mn = by_row(row, MN_NOP, MN_NOP, MN_NOP, MN_NOP,
                              MN_TXS, MN_TSX, MN_NOP, MN_NOP);
          default: begin
            if (row == 3'd4 && col == 3'd7) begin
              d.known = 1'b0;
            end else begin
              d.mn = by_row(row, MN_ASL, MN_ROL, MN_LSR, MN_ROR,
                            MN_STX, MN_LDX, MN_DEC, MN_INC);
            end
          end
        endcase
      end
      default: d.known = 1'b0;
    endcase
    if (!d.known) begin
      d.mn = mnemonic_t'(6'd0);
    end

    yidx = grp[1] && (row == 3'd4 || row == 3'd5);
    case (col)
      3'd0: begin
        if (grp == GRP_00) begin
          d.am = (row == 3'd1) ? AM_ABS : (row <= 3'd3) ? AM_IMPL : AM_IMM;
        end else begin
          d.am = (grp == GRP_10) ? AM_IMM : AM_IND;
        end
      end
      3'd1: d.am = AM_ZP;
      3'd2: begin
        if (grp == GRP_00) begin
          d.am = AM_IMPL;
        end else if (grp == GRP_10) begin
          d.am = (row <= 3'd3) ? AM_ACC : AM_IMPL;
        end else begin
          d.am = AM_IMM;
        end
      end
      3'd3: d.am = (grp == GRP_00 && row == 3'd3) ? AM_IND : AM_ABS;
      3'd4: d.am = (grp == GRP_00) ? AM_REL : AM_INDY;
      3'd5: d.am = yidx ? AM_ZPY : AM_ZPX;
      3'd6: d.am = grp[0] ? AM_ABSY : AM_IMPL;
      default: d.am = yidx ? AM_ABSY : AM_ABSX;
    endcase
    return d;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // A queue entry with bit 8 set holds the input until every request sent
  // so far has produced its result.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      opcode_byte <= 8'h00;
      quiet <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_decodes.push_back(decode_opcode(opcode_byte));
        n_accepted++;
      end
      quiet <= (pending_ops.size() < 100);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_ops[0][8]) begin
          in_valid <= 1'b0;
          if (n_checked == n_accepted) begin
            void'(pending_ops.pop_front());
          end
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else begin
          next_op = pending_ops.pop_front();
          in_valid <= 1'b1;
          opcode_byte <= next_op[7:0];
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_gap > 0) begin
        stall_gap--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_gap = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      if (out_valid && !out_stall) begin
        if (expected_decodes.size() == 0) begin
          $error("result with no request outstanding: known %0d mnemonic %0d mode %0d",
                 known, mnemonic, address_mode);
          errors++;
        end else begin
          want = expected_decodes.pop_front();
          n_checked <= n_checked + 1;
          if (known !== want.known) begin
            $error("known: expected %0d, got %0d", want.known, known);
            errors++;
          end
          if (mnemonic !== want.mn) begin
            $error("mnemonic: expected %0d, got %0d", want.mn, mnemonic);
            errors++;
          end
          if (address_mode !== want.am) begin
            $error("address_mode: expected %0d, got %0d", want.am, address_mode);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    logic [7:0] directed[$];
    directed = '{8'h00, 8'hFF, 8'h89, 8'h9C, 8'h9E, 8'h02, 8'hF2, 8'h04, 8'h80,
                 8'h1A, 8'h82, 8'h6C, 8'h20, 8'h10, 8'hB6, 8'hBE, 8'h96, 8'h0A,
                 8'hAA, 8'h9A, 8'h69, 8'h01, 8'h11, 8'h19, 8'h03};
    foreach (directed[i]) begin
      pending_ops.push_back({1'b0, directed[i]});
    end
    pending_ops.push_back(9'h100);
    repeat (220) begin
      pending_ops.push_back({1'b0, 8'($urandom_range(0, 255))});
    end
    for (int b = 0; b < 256; b++) begin
      pending_ops.push_back({1'b0, 8'(b)});
    end
    pending_ops.push_back(9'h100);
    repeat (224) begin
      pending_ops.push_back({1'b0, 8'($urandom_range(0, 255))});
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (!(pending_ops.size() == 0 && !in_valid && n_checked == n_accepted)) begin
      @(negedge clk);
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (expected_decodes.size() != 0) begin
      $error("%0d expected results never arrived", expected_decodes.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
